// ===== design/ntt_pkg.sv =====
package ntt_pkg;

   // Sizes
   localparam int MAX_LOG2_LEN = 12;
   localparam int WORD_BITS    = 62;
   localparam int STORE_DEPTH  = 1 << MAX_LOG2_LEN;
   localparam int ADDR_W       = MAX_LOG2_LEN;
   localparam int IDX_W        = MAX_LOG2_LEN + 1;
   localparam int LG_W         = 4;
   localparam int STAGE_W      = $clog2(MAX_LOG2_LEN);
   localparam int MUL_CNT_W    = $clog2(WORD_BITS);
   localparam int CSR_ADDR_W   = 6;
   localparam int CSR_DATA_W   = 64;

   // Register indexes, taken from paddr[5:3]
   localparam logic [2:0] CSR_MODULUS = 3'd0;
   localparam logic [2:0] CSR_LOG2    = 3'd1;
   localparam logic [2:0] CSR_DIR     = 3'd2;
   localparam logic [2:0] CSR_FROOT   = 3'd3;
   localparam logic [2:0] CSR_IROOT   = 3'd4;

   typedef logic [WORD_BITS-1:0] word_type;

   typedef enum logic [2:0] {
      MUL_A_ONE,
      MUL_A_RES,
      MUL_A_DIFF,
      MUL_A_B,
      MUL_A_W
   } mul_a_sel_type;

   typedef enum logic [2:0] {
      MUL_B_VAL,
      MUL_B_ROOT,
      MUL_B_RES,
      MUL_B_W,
      MUL_B_STEP
   } mul_b_sel_type;

   typedef enum logic [1:0] {
      WR_VAL,
      WR_RES,
      WR_SUM,
      WR_DIFF
   } wr_sel_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_LD_CHK,
      ST_LD_WAIT,
      ST_RT_WAIT,
      ST_STG,
      ST_BF_RA,
      ST_BF_RB,
      ST_BF_RC,
      ST_BF_OP,
      ST_F_WAIT,
      ST_I_WAIT,
      ST_I_W0,
      ST_I_W1,
      ST_BF_NEXT,
      ST_W_WAIT,
      ST_RD
   } state_type;

   typedef struct packed {
      logic                val_load;
      logic                mul_start;
      mul_a_sel_type       mul_a_sel;
      mul_b_sel_type       mul_b_sel;
      logic                ram_we;
      logic [ADDR_W-1:0]   ram_waddr;
      wr_sel_type          ram_wsel;
      logic [ADDR_W-1:0]   ram_raddr;
      logic                a_load_ram;
      logic                b_load_ram;
      logic                b_load_res;
      logic                root_wr;
      logic [STAGE_W-1:0]  root_idx;
      logic                step_load;
      logic                w_one;
      logic                w_load_res;
      logic                rsp_load;
      logic                rsp_last;
   } dp_cmd_type;

   typedef struct packed {
      logic val_lt_m;
      logic mul_done;
      logic mul_busy;
   } dp_status_type;

endpackage

// ===== design/ntt_req_if.sv =====
interface ntt_req_if import ntt_pkg::*; ();
   logic     valid;
   logic     ready;
   logic     kind;
   word_type value;

   modport source (output valid, output kind, output value, input ready);
   modport sink (input valid, input kind, input value, output ready);
endinterface

// ===== design/ntt_rsp_if.sv =====
interface ntt_rsp_if import ntt_pkg::*; ();
   logic     valid;
   logic     ready;
   word_type result_value;
   logic     last;

   modport source (output valid, output result_value, output last, input ready);
   modport sink (input valid, input result_value, input last, output ready);
endinterface

// ===== design/ntt_ram.sv =====
module ntt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // One write port, one registered read port
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== design/ntt_mulmod.sv =====
module ntt_mulmod import ntt_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     start,
   input  word_type op_a,
   input  word_type op_b,
   input  word_type modulus,
   output logic     busy,
   output logic     done,
   output word_type result
);

   word_type               r_ff, r_in;
   word_type               a_ff, a_in;
   word_type               b_ff, b_in;
   logic [MUL_CNT_W-1:0]   bit_ff, bit_in;
   logic                   phase_ff, phase_in;
   logic                   busy_ff, busy_in;
   logic                   done_ff, done_in;
   word_type               addend;
   logic [WORD_BITS:0]     sum;
   logic [WORD_BITS:0]     red;

   // Double on phase 0, add op_a on phase 1 when the multiplier bit is set
   always_comb begin
      addend = phase_ff ? (b_ff[WORD_BITS-1] ? a_ff : '0) : r_ff;
      sum    = {1'b0, r_ff} + {1'b0, addend};
      red    = (sum >= {1'b0, modulus}) ? sum - {1'b0, modulus} : sum;

      r_in     = r_ff;
      a_in     = a_ff;
      b_in     = b_ff;
      bit_in   = bit_ff;
      phase_in = phase_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;

      if (start) begin
         r_in     = '0;
         a_in     = op_a;
         b_in     = op_b;
         bit_in   = MUL_CNT_W'(WORD_BITS - 1);
         phase_in = 1'b0;
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         r_in     = red[WORD_BITS-1:0];
         phase_in = !phase_ff;
         if (phase_ff) begin
            b_in = {b_ff[WORD_BITS-2:0], 1'b0};
            if (bit_ff == '0) begin
               busy_in = 1'b0;
               done_in = 1'b1;
            end else begin
               bit_in = bit_ff - MUL_CNT_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      r_ff     <= r_in;
      a_ff     <= a_in;
      b_ff     <= b_in;
      bit_ff   <= bit_in;
      phase_ff <= phase_in;
   end

   assign busy   = busy_ff;
   assign done   = done_ff;
   assign result = r_ff;

endmodule

// ===== design/ntt_dp.sv =====
module ntt_dp import ntt_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  word_type      req_value,
   input  word_type      root_raw,
   input  word_type      modulus,
   input  dp_cmd_type    cmd,
   output dp_status_type status,
   output word_type      rsp_value,
   output logic          rsp_last
);

   word_type           val_ff, val_in;
   word_type           a_ff, a_in;
   word_type           b_ff, b_in;
   word_type           w_ff, w_in;
   word_type           step_ff, step_in;
   word_type           roots_ff [MAX_LOG2_LEN];
   word_type           rsp_value_ff, rsp_value_in;
   logic               rsp_last_ff, rsp_last_in;
   word_type           mul_a;
   word_type           mul_b;
   word_type           mul_res;
   logic               mul_busy;
   logic               mul_done;
   word_type           ram_wdata;
   word_type           ram_rdata;
   logic [WORD_BITS:0] add_raw;
   logic [WORD_BITS:0] sub_raw;
   word_type           sum;
   word_type           diff;

   // Modular add and subtract of the butterfly operands
   always_comb begin
      add_raw = {1'b0, a_ff} + {1'b0, b_ff};
      if (add_raw >= {1'b0, modulus}) begin
         add_raw = add_raw - {1'b0, modulus};
      end
      sum     = add_raw[WORD_BITS-1:0];
      sub_raw = {1'b0, a_ff} - {1'b0, b_ff};
      if (sub_raw[WORD_BITS]) begin
         sub_raw = sub_raw + {1'b0, modulus};
      end
      diff = sub_raw[WORD_BITS-1:0];
   end

   // Multiplier operand and store write data select
   always_comb begin
      case (cmd.mul_a_sel)
         MUL_A_ONE:  mul_a = word_type'(1);
         MUL_A_RES:  mul_a = mul_res;
         MUL_A_DIFF: mul_a = diff;
         MUL_A_B:    mul_a = b_ff;
         MUL_A_W:    mul_a = w_ff;
         default:    mul_a = word_type'(1);
      endcase
      case (cmd.mul_b_sel)
         MUL_B_VAL:  mul_b = val_ff;
         MUL_B_ROOT: mul_b = root_raw;
         MUL_B_RES:  mul_b = mul_res;
         MUL_B_W:    mul_b = w_ff;
         MUL_B_STEP: mul_b = step_ff;
         default:    mul_b = val_ff;
      endcase
      case (cmd.ram_wsel)
         WR_VAL:  ram_wdata = val_ff;
         WR_RES:  ram_wdata = mul_res;
         WR_SUM:  ram_wdata = sum;
         WR_DIFF: ram_wdata = diff;
         default: ram_wdata = val_ff;
      endcase
   end

   ntt_mulmod u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (cmd.mul_start),
      .op_a    (mul_a),
      .op_b    (mul_b),
      .modulus (modulus),
      .busy    (mul_busy),
      .done    (mul_done),
      .result  (mul_res)
   );

   ntt_ram #(
      .WIDTH (WORD_BITS),
      .DEPTH (STORE_DEPTH)
   ) u_store (
      .clock (clock),
      .we    (cmd.ram_we),
      .waddr (cmd.ram_waddr),
      .wdata (ram_wdata),
      .raddr (cmd.ram_raddr),
      .rdata (ram_rdata)
   );

   // Operand and twiddle registers
   always_comb begin
      val_in       = cmd.val_load ? req_value : val_ff;
      a_in         = cmd.a_load_ram ? ram_rdata : a_ff;
      b_in         = b_ff;
      if (cmd.b_load_ram) begin
         b_in = ram_rdata;
      end else if (cmd.b_load_res) begin
         b_in = mul_res;
      end
      w_in         = w_ff;
      if (cmd.w_one) begin
         w_in = word_type'(1);
      end else if (cmd.w_load_res) begin
         w_in = mul_res;
      end
      step_in      = cmd.step_load ? roots_ff[cmd.root_idx] : step_ff;
      rsp_value_in = cmd.rsp_load ? ram_rdata : rsp_value_ff;
      rsp_last_in  = cmd.rsp_load ? cmd.rsp_last : rsp_last_ff;
   end

   always_ff @(posedge clock) begin
      val_ff       <= val_in;
      a_ff         <= a_in;
      b_ff         <= b_in;
      w_ff         <= w_in;
      step_ff      <= step_in;
      rsp_value_ff <= rsp_value_in;
      rsp_last_ff  <= rsp_last_in;
      if (cmd.root_wr) begin
         roots_ff[cmd.root_idx] <= mul_res;
      end
   end

   assign status.val_lt_m = (val_ff < modulus);
   assign status.mul_done = mul_done;
   assign status.mul_busy = mul_busy;
   assign rsp_value       = rsp_value_ff;
   assign rsp_last        = rsp_last_ff;

endmodule

// ===== design/ntt_ctrl.sv =====
module ntt_ctrl import ntt_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   input  logic            req_kind,
   output logic            req_ready,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   input  logic [LG_W-1:0] eff_lg,
   input  logic            direction,
   input  dp_status_type   status,
   output dp_cmd_type      cmd
);

   state_type           state_ff, state_in;
   logic [IDX_W-1:0]    li_ff, li_in;
   logic [IDX_W-1:0]    ri_ff, ri_in;
   logic                done_ff, done_in;
   logic [STAGE_W-1:0]  k_ff, k_in;
   logic [IDX_W-1:0]    s_ff, s_in;
   logic [IDX_W-1:0]    i_ff, i_in;
   logic                rspv_ff, rspv_in;
   logic [IDX_W-1:0]    n;
   logic [STAGE_W-1:0]  st;
   logic [STAGE_W-1:0]  last_k;
   logic [IDX_W-1:0]    span;
   logic [IDX_W-1:0]    half;
   logic [IDX_W-1:0]    p0;
   logic [IDX_W-1:0]    p1;
   logic                fin;
   logic                load_full;

   // Transform geometry of the current stage
   always_comb begin
      n         = IDX_W'(1) << eff_lg;
      last_k    = STAGE_W'(eff_lg) - STAGE_W'(1);
      st        = direction ? (last_k - k_ff) : k_ff;
      span      = n >> st;
      half      = span >> 1;
      p0        = s_ff + i_ff;
      p1        = p0 + half;
      fin       = (ri_ff + IDX_W'(1)) >= n;
      load_full = (li_ff + IDX_W'(1)) >= n;
   end

   // Next state and commands
   always_comb begin
      state_in = state_ff;
      li_in    = li_ff;
      ri_in    = ri_ff;
      done_in  = done_ff;
      k_in     = k_ff;
      s_in     = s_ff;
      i_in     = i_ff;
      req_ready = 1'b0;

      cmd           = '0;
      cmd.ram_raddr = ri_ff[ADDR_W-1:0];
      cmd.ram_waddr = li_ff[ADDR_W-1:0];
      cmd.root_idx  = st;

      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (!req_kind) begin
                  if (!done_ff) begin
                     cmd.val_load = 1'b1;
                     state_in     = ST_LD_CHK;
                  end
               end else if (done_ff) begin
                  state_in = ST_RD;
               end
            end
         end
         ST_LD_CHK, ST_LD_WAIT: begin
            if (state_ff == ST_LD_CHK && !status.val_lt_m) begin
               cmd.mul_start = 1'b1;
               cmd.mul_a_sel = MUL_A_ONE;
               cmd.mul_b_sel = MUL_B_VAL;
               state_in      = ST_LD_WAIT;
            end else if (state_ff == ST_LD_CHK || status.mul_done) begin
               // Store the reduced element and advance the load index, or after the last one start the roots
               cmd.ram_we   = 1'b1;
               cmd.ram_wsel = (state_ff == ST_LD_CHK) ? WR_VAL : WR_RES;
               if (load_full) begin
                  li_in         = '0;
                  k_in          = '0;
                  cmd.mul_start = 1'b1;
                  cmd.mul_a_sel = MUL_A_ONE;
                  cmd.mul_b_sel = MUL_B_ROOT;
                  state_in      = ST_RT_WAIT;
               end else begin
                  li_in    = li_ff + IDX_W'(1);
                  state_in = ST_IDLE;
               end
            end
         end
         ST_RT_WAIT: begin
            // Reduce the root, then square it once for each further stage
            cmd.root_idx = k_ff;
            if (status.mul_done) begin
               cmd.root_wr = 1'b1;
               if (k_ff == last_k) begin
                  k_in     = '0;
                  state_in = ST_STG;
               end else begin
                  k_in          = k_ff + STAGE_W'(1);
                  cmd.mul_start = 1'b1;
                  cmd.mul_a_sel = MUL_A_RES;
                  cmd.mul_b_sel = MUL_B_RES;
               end
            end
         end
         ST_STG: begin
            cmd.step_load = 1'b1;
            cmd.w_one     = 1'b1;
            s_in          = '0;
            i_in          = '0;
            state_in      = ST_BF_RA;
         end
         ST_BF_RA: begin
            cmd.ram_raddr = p1[ADDR_W-1:0];
            state_in      = ST_BF_RB;
         end
         ST_BF_RB: begin
            cmd.ram_raddr  = p0[ADDR_W-1:0];
            cmd.b_load_ram = 1'b1;
            state_in       = ST_BF_RC;
         end
         ST_BF_RC: begin
            cmd.a_load_ram = 1'b1;
            state_in       = ST_BF_OP;
         end
         ST_BF_OP: begin
            cmd.mul_start = 1'b1;
            cmd.mul_b_sel = MUL_B_W;
            if (!direction) begin
               cmd.ram_we    = 1'b1;
               cmd.ram_waddr = p0[ADDR_W-1:0];
               cmd.ram_wsel  = WR_SUM;
               cmd.mul_a_sel = MUL_A_DIFF;
               state_in      = ST_F_WAIT;
            end else begin
               cmd.mul_a_sel = MUL_A_B;
               state_in      = ST_I_WAIT;
            end
         end
         ST_F_WAIT: begin
            if (status.mul_done) begin
               cmd.ram_we    = 1'b1;
               cmd.ram_waddr = p1[ADDR_W-1:0];
               cmd.ram_wsel  = WR_RES;
               state_in      = ST_BF_NEXT;
            end
         end
         ST_I_WAIT: begin
            if (status.mul_done) begin
               cmd.b_load_res = 1'b1;
               state_in       = ST_I_W0;
            end
         end
         ST_I_W0: begin
            cmd.ram_we    = 1'b1;
            cmd.ram_waddr = p0[ADDR_W-1:0];
            cmd.ram_wsel  = WR_SUM;
            state_in      = ST_I_W1;
         end
         ST_I_W1: begin
            cmd.ram_we    = 1'b1;
            cmd.ram_waddr = p1[ADDR_W-1:0];
            cmd.ram_wsel  = WR_DIFF;
            state_in      = ST_BF_NEXT;
         end
         ST_BF_NEXT: begin
            if ((i_ff + IDX_W'(1)) < half) begin
               cmd.mul_start = 1'b1;
               cmd.mul_a_sel = MUL_A_W;
               cmd.mul_b_sel = MUL_B_STEP;
               state_in      = ST_W_WAIT;
            end else begin
               // End of a block: restart the twiddle
               i_in      = '0;
               cmd.w_one = 1'b1;
               if ((s_ff + span) >= n) begin
                  if (k_ff == last_k) begin
                     done_in  = 1'b1;
                     li_in    = '0;
                     ri_in    = '0;
                     k_in     = '0;
                     state_in = ST_IDLE;
                  end else begin
                     k_in     = k_ff + STAGE_W'(1);
                     state_in = ST_STG;
                  end
               end else begin
                  s_in     = s_ff + span;
                  state_in = ST_BF_RA;
               end
            end
         end
         ST_W_WAIT: begin
            if (status.mul_done) begin
               cmd.w_load_res = 1'b1;
               i_in           = i_ff + IDX_W'(1);
               state_in       = ST_BF_RA;
            end
         end
         ST_RD: begin
            // Hold the read data until the output register frees up
            if (!rspv_ff || rsp_ready) begin
               cmd.rsp_load = 1'b1;
               cmd.rsp_last = fin;
               if (fin) begin
                  done_in = 1'b0;
                  ri_in   = '0;
                  li_in   = '0;
               end else begin
                  ri_in = ri_ff + IDX_W'(1);
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      rspv_in = rspv_ff;
      if (cmd.rsp_load) begin
         rspv_in = 1'b1;
      end else if (rsp_ready) begin
         rspv_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         li_ff    <= '0;
         ri_ff    <= '0;
         done_ff  <= 1'b0;
         k_ff     <= '0;
         s_ff     <= '0;
         i_ff     <= '0;
         rspv_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         li_ff    <= li_in;
         ri_ff    <= ri_in;
         done_ff  <= done_in;
         k_ff     <= k_in;
         s_ff     <= s_in;
         i_ff     <= i_in;
         rspv_ff  <= rspv_in;
      end
   end

   assign rsp_valid = rspv_ff;

endmodule

// ===== design/ntt_radix2_mod_prime.sv =====
// Load request: the value is stored as it is, or first reduced by the multiplier when it is
// not below the modulus. Read request: the next element goes to the output register once
// that register is free. Transform after the last load: the roots are reduced and squared,
// then (N/2)*log2(N) butterflies run, each on the bit-serial multiplier.
// Reset (synchronous, active high) clears control state and the configuration registers;
// the element store holds no reset and needs no clearing pass.
module ntt_radix2_mod_prime import ntt_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   ntt_req_if.sink               req_if,
   ntt_rsp_if.source             rsp_if,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   word_type        modulus_ff, modulus_in;
   logic [LG_W-1:0] log2_ff, log2_in;
   logic            dir_ff, dir_in;
   word_type        froot_ff, froot_in;
   word_type        iroot_ff, iroot_in;
   logic            csr_wr;
   logic [2:0]      csr_idx;
   word_type        eff_mod;
   logic [LG_W-1:0] eff_lg;
   word_type        root_raw;
   dp_cmd_type      cmd;
   dp_status_type   status;

   // Register writes
   always_comb begin
      csr_wr     = csr_psel && csr_penable && csr_pwrite;
      csr_idx    = csr_paddr[CSR_ADDR_W-1:3];
      modulus_in = modulus_ff;
      log2_in    = log2_ff;
      dir_in     = dir_ff;
      froot_in   = froot_ff;
      iroot_in   = iroot_ff;
      if (csr_wr) begin
         unique case (csr_idx)
            CSR_MODULUS: modulus_in = csr_pwdata[WORD_BITS-1:0];
            CSR_LOG2:    log2_in    = csr_pwdata[LG_W-1:0];
            CSR_DIR:     dir_in     = csr_pwdata[0];
            CSR_FROOT:   froot_in   = csr_pwdata[WORD_BITS-1:0];
            CSR_IROOT:   iroot_in   = csr_pwdata[WORD_BITS-1:0];
            default:     ;
         endcase
      end
   end

   // Register reads
   always_comb begin
      unique case (csr_idx)
         CSR_MODULUS: csr_prdata = CSR_DATA_W'(modulus_ff);
         CSR_LOG2:    csr_prdata = CSR_DATA_W'(log2_ff);
         CSR_DIR:     csr_prdata = CSR_DATA_W'(dir_ff);
         CSR_FROOT:   csr_prdata = CSR_DATA_W'(froot_ff);
         CSR_IROOT:   csr_prdata = CSR_DATA_W'(iroot_ff);
         default:     csr_prdata = '0;
      endcase
   end

   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         modulus_ff <= word_type'(3);
         log2_ff    <= LG_W'(1);
         dir_ff     <= 1'b0;
         froot_ff   <= '0;
         iroot_ff   <= '0;
      end else begin
         modulus_ff <= modulus_in;
         log2_ff    <= log2_in;
         dir_ff     <= dir_in;
         froot_ff   <= froot_in;
         iroot_ff   <= iroot_in;
      end
   end

   // Clamp modulus and length to their working ranges
   always_comb begin
      eff_mod = (modulus_ff < word_type'(3)) ? word_type'(3) : modulus_ff;
      if (log2_ff == '0) begin
         eff_lg = LG_W'(1);
      end else if (log2_ff > LG_W'(MAX_LOG2_LEN)) begin
         eff_lg = LG_W'(MAX_LOG2_LEN);
      end else begin
         eff_lg = log2_ff;
      end
      root_raw = dir_ff ? iroot_ff : froot_ff;
   end

   ntt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_kind  (req_if.kind),
      .req_ready (req_if.ready),
      .rsp_valid (rsp_if.valid),
      .rsp_ready (rsp_if.ready),
      .eff_lg    (eff_lg),
      .direction (dir_ff),
      .status    (status),
      .cmd       (cmd)
   );

   ntt_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_value (req_if.value),
      .root_raw  (root_raw),
      .modulus   (eff_mod),
      .cmd       (cmd),
      .status    (status),
      .rsp_value (rsp_if.result_value),
      .rsp_last  (rsp_if.last)
   );

`ifndef SYNTHESIS
   a_mul_start_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.mul_start |-> !status.mul_busy)
      else $error("multiplier started while busy");

   a_rsp_from_load: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_if.valid) |-> $past(cmd.rsp_load))
      else $error("response valid without a load");

   a_no_write_on_accept: assert property (@(posedge clock) disable iff (reset)
      cmd.ram_we |-> !(req_if.valid && req_if.ready))
      else $error("store write while accepting a request");
`endif

endmodule
